// ----- rtl/ple_pkg.sv -----
package ple_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int MODE_W    = 2;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int LEN_OUT_W = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_REMOVE = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ----- rtl/ple_mem.sv -----
module ple_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
        r_rdata <= r_store[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Ordered list of up to DEPTH entries, each an identifier and a signed amount.
// Input channel: i_valid with o_stall; a command beat carries mode, entry id,
// amount and position. Output channel: o_valid with i_stall; every command
// gives exactly one result beat with status, read data and the new length.
// Entries live in a single-port-write, registered-read memory. A small
// sequencer moves entries one at a time through that port to open or close
// a gap, reading each entry in S_RD and writing it in S_WR. Insert shifts
// the entries from the position on and remove shifts those behind it;
// append, and insert on an empty list, write the entry at once; a read
// fetches it from the memory; a failed command goes straight to the result.
// One command is worked on at a time; o_stall is high from acceptance until
// the result has been loaded. A result waits in the output register while
// i_stall is high, and the next command may be accepted meanwhile. Reset
// empties the list and drops any pending result; the memory contents are
// not cleared.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [ple_pkg::MODE_W-1:0]             i_mode,
    input  logic signed [ple_pkg::DATA_W-1:0]      i_entry_id,
    input  logic signed [ple_pkg::DATA_W-1:0]      i_amount,
    input  logic [ple_pkg::POS_W-1:0]              i_position,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [ple_pkg::STATUS_W-1:0]           o_status,
    output logic signed [ple_pkg::DATA_W-1:0]      o_read_id,
    output logic signed [ple_pkg::DATA_W-1:0]      o_read_amount,
    output logic [ple_pkg::LEN_OUT_W-1:0]          o_length
);

    import ple_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int EW = 2 * DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_WR,
        S_PUT,
        S_FETCH,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [LW-1:0]        r_len, n_len;
    logic [AW-1:0]        r_k, n_k;
    logic                 r_open, n_open;
    t_mode                r_mode, n_mode;
    logic [DATA_W-1:0]    r_nid, n_nid;
    logic [DATA_W-1:0]    r_namt, n_namt;
    logic [POS_W-1:0]     r_pos, n_pos;
    t_status              r_res_status, n_res_status;
    logic [DATA_W-1:0]    r_res_id, n_res_id;
    logic [DATA_W-1:0]    r_res_amt, n_res_amt;
    logic                 r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]  r_ostatus, n_ostatus;
    logic [DATA_W-1:0]    r_oid, n_oid;
    logic [DATA_W-1:0]    r_oamt, n_oamt;
    logic [LEN_OUT_W-1:0] r_olen, n_olen;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [EW-1:0]        w_rdata;

    logic [CW-1:0]        w_pos_ext;
    logic [CW-1:0]        w_len_ext;
    logic                 w_in_range;
    logic                 w_full;
    logic [AW-1:0]        w_pos_a;

    assign w_pos_ext  = CW'(r_pos);
    assign w_len_ext  = CW'(r_len);
    assign w_in_range = w_pos_ext < w_len_ext;
    assign w_full     = r_len == LW'(DEPTH);
    assign w_pos_a    = AW'(r_pos);

    ple_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (EW),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_k          = r_k;
        n_open       = r_open;
        n_mode       = r_mode;
        n_nid        = r_nid;
        n_namt       = r_namt;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_amt    = r_res_amt;
        n_ovalid     = r_ovalid;
        n_ostatus    = r_ostatus;
        n_oid        = r_oid;
        n_oamt       = r_oamt;
        n_olen       = r_olen;
        w_we         = 1'b0;
        w_waddr      = r_k;
        w_wdata      = {r_nid, r_namt};
        w_raddr      = w_pos_a;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = t_mode'(i_mode);
                    n_nid   = i_entry_id;
                    n_namt  = i_amount;
                    n_pos   = i_position;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status = ST_DONE;
                n_res_id     = '0;
                n_res_amt    = '0;
                n_state      = S_DONE;
                unique case (r_mode)
                    MODE_REMOVE: begin
                        if (w_in_range) begin
                            n_k     = w_pos_a;
                            n_open  = 1'b0;
                            n_state = S_RD;
                        end else begin
                            n_res_status = ST_RANGE;
                        end
                    end
                    MODE_APPEND: begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_k     = AW'(r_len);
                            n_state = S_PUT;
                        end
                    end
                    MODE_INSERT: begin
                        if (r_len == '0) begin
                            if (r_pos == '0) begin
                                n_k     = '0;
                                n_state = S_PUT;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end else if (!w_in_range) begin
                            n_res_status = ST_RANGE;
                        end else if (w_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_k     = AW'(r_len);
                            n_open  = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    MODE_READ: begin
                        // The memory read at the position is already under way.
                        if (w_in_range) begin
                            n_state = S_FETCH;
                        end else begin
                            n_res_status = ST_RANGE;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                if (r_open) begin
                    w_raddr = r_k - AW'(1);
                    if (r_k == w_pos_a) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_WR;
                    end
                end else begin
                    w_raddr = r_k + AW'(1);
                    if ((LW'(r_k) + LW'(1)) >= r_len) begin
                        n_len   = r_len - LW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_k     = r_open ? (r_k - AW'(1)) : (r_k + AW'(1));
                n_state = S_RD;
            end
            S_PUT: begin
                w_we    = 1'b1;
                n_len   = r_len + LW'(1);
                n_state = S_DONE;
            end
            S_FETCH: begin
                n_res_id  = w_rdata[EW-1:DATA_W];
                n_res_amt = w_rdata[DATA_W-1:0];
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_oid     = r_res_id;
                    n_oamt    = r_res_amt;
                    n_olen    = LEN_OUT_W'(r_len);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
        r_k          <= n_k;
        r_open       <= n_open;
        r_mode       <= n_mode;
        r_nid        <= n_nid;
        r_namt       <= n_namt;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_amt    <= n_res_amt;
        r_ostatus    <= n_ostatus;
        r_oid        <= n_oid;
        r_oamt       <= n_oamt;
        r_olen       <= n_olen;
    end

    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_read_id     = r_oid;
    assign o_read_amount = r_oamt;
    assign o_length      = r_olen;

endmodule
